[hdl/kfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad frequency entry package
// Word types, event codes, key codes, register indexes and small tables
// shared by the entry controller, its output buffer and its checker.
// ----------------------------------------------------------------------------
package kfe_pkg;

    localparam int unsigned DIGITS_MAX = 7;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned BCD_W      = 4 * DIGITS_MAX;
    localparam int unsigned HZ_W       = 27;
    localparam int unsigned OSC_W      = 28;
    localparam int unsigned IDLE_W     = 13;
    localparam int unsigned STEP_W     = 14;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [IDLE_W-1:0] IDLE_SAT = '1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IF_HZ   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HZ  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HZ  = 8'd3;

    // Reset values.
    localparam logic [HZ_W-1:0]   RST_IF_HZ   = 27'd0;
    localparam logic [IDLE_W-1:0] RST_TIMEOUT = 13'd5000;
    localparam logic [HZ_W-1:0]   RST_MIN_HZ  = 27'd1_000_000;
    localparam logic [HZ_W-1:0]   RST_MAX_HZ  = 27'd30_000_000;
    localparam logic [HZ_W-1:0]   RST_FREQ_HZ = 27'd7_000_000;
    localparam logic [1:0]        RST_STEP    = 2'd2;

    // ASCII key codes.
    localparam logic [7:0] KEY_0       = 8'h30;
    localparam logic [7:0] KEY_9       = 8'h39;
    localparam logic [7:0] KEY_STAR    = 8'h2A;
    localparam logic [7:0] KEY_HASH    = 8'h23;
    localparam logic [7:0] KEY_A_UPPER = 8'h41;
    localparam logic [7:0] KEY_A_LOWER = 8'h61;
    localparam logic [7:0] KEY_C_UPPER = 8'h43;
    localparam logic [7:0] KEY_C_LOWER = 8'h63;

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_STARTED   = 4'd1,
        EV_ADDED     = 4'd2,
        EV_REFUSED   = 4'd3,
        EV_ACCEPTED  = 4'd4,
        EV_REJECTED  = 4'd5,
        EV_CANCELLED = 4'd6,
        EV_TIMED_OUT = 4'd7,
        EV_STEP      = 4'd8
    } t_event;

    typedef struct packed {
        logic       func;
        logic [7:0] key;
    } t_in_word;

    typedef struct packed {
        logic [3:0]        event_res;
        logic              entry_active;
        logic [CNT_W-1:0]  digit_count;
        logic [BCD_W-1:0]  entered_digits;
        logic [HZ_W-1:0]   tuned_frequency;
        logic [OSC_W-1:0]  oscillator_frequency;
        logic [STEP_W-1:0] step_hz;
    } t_out_word;

    // Contribution in Hz of a digit typed at a given position. A short kHz or
    // tens field is scaled up, so each position carries one fixed weight.
    function automatic logic [HZ_W-1:0] digit_hz(input logic [CNT_W-1:0] pos,
                                                 input logic [3:0] dig);
        logic [HZ_W-1:0] w;
        case (pos)
            3'd0:    w = 27'd10_000_000;
            3'd1:    w = 27'd1_000_000;
            3'd2:    w = 27'd100_000;
            3'd3:    w = 27'd10_000;
            3'd4:    w = 27'd1_000;
            3'd5:    w = 27'd100;
            3'd6:    w = 27'd10;
            default: w = 27'd0;
        endcase
        return w * {{(HZ_W-4){1'b0}}, dig};
    endfunction

    function automatic logic [STEP_W-1:0] step_to_hz(input logic [1:0] idx);
        logic [STEP_W-1:0] hz;
        case (idx)
            2'd0:    hz = 14'd10;
            2'd1:    hz = 14'd100;
            2'd2:    hz = 14'd1000;
            default: hz = 14'd10000;
        endcase
        return hz;
    endfunction

endpackage

[hdl/keypad_frequency_entry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad frequency entry controller
// An accepted word's result is written to o_out_word's register when that
// register is free, else to the skid entry. Throughput: one word per cycle,
// held back only when the output register and its skid entry are both full.
// Reset: synchronous, active low; tuned frequency 7 MHz, step 1 kHz, entry
// mode off, configuration registers at their defaults.
// ----------------------------------------------------------------------------
module keypad_frequency_entry
    import kfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [HZ_W-1:0]      i_cfg_data
);

    logic [HZ_W-1:0]   r_if_hz;
    logic [IDLE_W-1:0] r_timeout;
    logic [HZ_W-1:0]   r_min_hz;
    logic [HZ_W-1:0]   r_max_hz;

    logic              r_entry, n_entry;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDLE_W-1:0] r_idle,  n_idle;
    logic [HZ_W-1:0]   r_freq,  n_freq;
    logic [1:0]        r_step,  n_step;
    logic [BCD_W-1:0]  r_digits, n_digits;
    logic [HZ_W-1:0]   r_hz,    n_hz;

    t_event    ev;
    t_out_word res;
    logic      accept;
    logic      is_digit;
    logic [3:0] dig;
    logic      len_ok;
    logic [IDLE_W-1:0] idle_inc;
    logic      skid_full;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !skid_full;
    assign o_in_stall  = skid_full;

    assign is_digit = (i_in_word.key >= KEY_0) && (i_in_word.key <= KEY_9);
    assign dig      = i_in_word.key[3:0];
    // Two digits give whole MHz; four to seven give MHz, kHz and tens of Hz.
    assign len_ok   = (r_count == 3'd2) || (r_count >= 3'd4);
    assign idle_inc = (r_idle == IDLE_SAT) ? r_idle : r_idle + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_hz   <= RST_IF_HZ;
            r_timeout <= RST_TIMEOUT;
            r_min_hz  <= RST_MIN_HZ;
            r_max_hz  <= RST_MAX_HZ;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IF_HZ:   r_if_hz   <= i_cfg_data;
                CFG_TIMEOUT: r_timeout <= i_cfg_data[IDLE_W-1:0];
                CFG_MIN_HZ:  r_min_hz  <= i_cfg_data;
                CFG_MAX_HZ:  r_max_hz  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_entry  = r_entry;
        n_count  = r_count;
        n_idle   = r_idle;
        n_freq   = r_freq;
        n_step   = r_step;
        n_digits = r_digits;
        n_hz     = r_hz;
        ev       = EV_NONE;

        if (i_in_word.func == FUNC_TICK) begin
            if (r_entry) begin
                n_idle = idle_inc;
                if (idle_inc > r_timeout) begin
                    n_entry  = 1'b0;
                    n_count  = '0;
                    n_digits = '0;
                    ev       = EV_TIMED_OUT;
                end
            end
        end else if (r_entry) begin
            if (is_digit) begin
                n_idle = '0;
                if (r_count < CNT_W'(DIGITS_MAX)) begin
                    for (int i = 0; i < DIGITS_MAX; i++) begin
                        if (r_count == CNT_W'(i)) begin
                            n_digits[BCD_W-1-4*i -: 4] = dig;
                        end
                    end
                    // The frequency value is built up as digits arrive.
                    n_hz    = r_hz + digit_hz(r_count, dig);
                    n_count = r_count + 1'b1;
                    ev      = EV_ADDED;
                end else begin
                    ev = EV_REFUSED;
                end
            end else if (i_in_word.key == KEY_A_UPPER || i_in_word.key == KEY_A_LOWER) begin
                if (len_ok && r_hz >= r_min_hz && r_hz <= r_max_hz) begin
                    n_freq = r_hz;
                    ev     = EV_ACCEPTED;
                end else begin
                    ev = EV_REJECTED;
                end
                n_entry  = 1'b0;
                n_count  = '0;
                n_digits = '0;
            end else if (i_in_word.key == KEY_C_UPPER || i_in_word.key == KEY_C_LOWER
                         || i_in_word.key == KEY_HASH) begin
                n_entry  = 1'b0;
                n_count  = '0;
                n_digits = '0;
                ev       = EV_CANCELLED;
            end
        end else begin
            if (i_in_word.key == KEY_STAR) begin
                n_step = r_step - 1'b1;
                ev     = EV_STEP;
            end else if (i_in_word.key == KEY_HASH) begin
                n_step = r_step + 1'b1;
                ev     = EV_STEP;
            end else if (is_digit) begin
                n_entry  = 1'b1;
                n_count  = 3'd1;
                n_idle   = '0;
                n_digits = {dig, {(BCD_W-4){1'b0}}};
                n_hz     = digit_hz(3'd0, dig);
                ev       = EV_STARTED;
            end
        end
    end

    always_comb begin
        res.event_res            = ev;
        res.entry_active         = n_entry;
        res.digit_count          = n_count;
        res.entered_digits       = n_digits;
        res.tuned_frequency      = n_freq;
        res.oscillator_frequency = {1'b0, n_freq} + {1'b0, r_if_hz};
        res.step_hz              = step_to_hz(n_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry  <= 1'b0;
            r_count  <= '0;
            r_idle   <= '0;
            r_freq   <= RST_FREQ_HZ;
            r_step   <= RST_STEP;
            r_digits <= '0;
        end else if (accept) begin
            r_entry  <= n_entry;
            r_count  <= n_count;
            r_idle   <= n_idle;
            r_freq   <= n_freq;
            r_step   <= n_step;
            r_digits <= n_digits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hz <= n_hz;
        end
    end

    kfe_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_word  (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .o_full  (skid_full)
    );

endmodule

[hdl/kfe_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output buffer
// Output register with one skid entry, so that a word can be accepted while
// the previous result still waits for the consumer.
// ----------------------------------------------------------------------------
module kfe_out_buf
    import kfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_word,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_word o_word,
    output logic      o_full
);

    logic      r_valid;
    logic      r_skid_valid;
    t_out_word r_word;
    t_out_word r_skid;
    logic      take;
    logic      main_free;

    assign take      = r_valid && !i_stall;
    assign main_free = !r_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_push) begin
                // The producer only pushes while the skid entry is empty.
                if (main_free) begin
                    r_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (main_free) begin
                r_word <= i_word;
            end else begin
                r_skid <= i_word;
            end
        end else if (take && r_skid_valid) begin
            r_word <= r_skid;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_full  = r_skid_valid;

endmodule

[hdl/kfe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad frequency entry checker
// Port-level properties of the entry controller, bound to the top level.
// ----------------------------------------------------------------------------
module kfe_checker
    import kfe_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input t_in_word             i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_word            o_out_word,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [HZ_W-1:0]      i_cfg_data
);

    // Nothing is offered to the consumer right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("result word present right after reset");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // Outside entry mode no digits are shown.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.entry_active |->
            o_out_word.digit_count == '0 && o_out_word.entered_digits == '0)
        else $error("digits shown outside entry mode");

    // A confirm ends entry mode.
    a_confirm_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.event_res == EV_ACCEPTED
                        || o_out_word.event_res == EV_REJECTED) |->
            !o_out_word.entry_active)
        else $error("entry mode still on after confirm");

    // A new entry holds exactly its first digit.
    a_start_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_res == EV_STARTED |->
            o_out_word.entry_active && o_out_word.digit_count == 3'd1)
        else $error("new entry does not hold one digit");

endmodule

bind keypad_frequency_entry kfe_checker u_kfe_checker (.*);

[verif/tb_keypad_frequency_entry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad frequency entry testbench
// Drives key and tick words into the entry controller with random gaps and
// output stalls. It predicts each status word from its own model of the
// entry state, then compares every received word field by field. A short
// script covers step wrapping, accepts, rejects, cancels and the digit limit.
// Configuration phases follow: extremes, a long timeout, inverted limits
// and random settings, each with its own random key traffic.
// ----------------------------------------------------------------------------
module tb_keypad_frequency_entry;
    import kfe_pkg::*;

    typedef struct packed {
        logic              func;
        logic [7:0]        key;
        logic              typed;
        t_event            ev;
        logic [HZ_W-1:0]   hz;
        logic [STEP_W-1:0] step;
    } t_row;

    localparam logic [7:0] KEY_B_UPPER = 8'h42;
    localparam logic [STEP_W-1:0] STEP_HZ [4] = '{14'd10, 14'd100, 14'd1000, 14'd10000};

    // Rows with typed set carry the event, tuned frequency and step by hand.
    localparam int SCRIPT_LEN = 28;
    localparam t_row SCRIPT [SCRIPT_LEN] = '{
        '{FUNC_TICK, 8'h00,        1'b1, EV_NONE,      27'd7_000_000,  14'd1000},
        '{FUNC_KEY,  KEY_STAR,     1'b1, EV_STEP,      27'd7_000_000,  14'd100},
        '{FUNC_KEY,  KEY_STAR,     1'b1, EV_STEP,      27'd7_000_000,  14'd10},
        '{FUNC_KEY,  KEY_STAR,     1'b1, EV_STEP,      27'd7_000_000,  14'd10000},
        '{FUNC_KEY,  KEY_HASH,     1'b1, EV_STEP,      27'd7_000_000,  14'd10},
        '{FUNC_KEY,  8'hFF,        1'b1, EV_NONE,      27'd7_000_000,  14'd10},
        '{FUNC_KEY,  KEY_0 + 8'd1, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_0 + 8'd4, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_A_UPPER,  1'b1, EV_ACCEPTED,  27'd14_000_000, 14'd10},
        '{FUNC_KEY,  KEY_9,        1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_9,        1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_A_LOWER,  1'b1, EV_REJECTED,  27'd14_000_000, 14'd10},
        '{FUNC_KEY,  KEY_0 + 8'd3, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_A_UPPER,  1'b1, EV_REJECTED,  27'd14_000_000, 14'd10},
        '{FUNC_KEY,  KEY_0,        1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_0 + 8'd7, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_0 + 8'd1, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_0 + 8'd2, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_0 + 8'd3, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_0 + 8'd4, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_0 + 8'd5, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_0 + 8'd8, 1'b1, EV_REFUSED,   27'd14_000_000, 14'd10},
        '{FUNC_TICK, 8'hFF,        1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_A_UPPER,  1'b1, EV_ACCEPTED,  27'd7_123_450,  14'd10},
        '{FUNC_KEY,  KEY_0 + 8'd5, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_C_UPPER,  1'b1, EV_CANCELLED, 27'd7_123_450,  14'd10},
        '{FUNC_KEY,  KEY_0 + 8'd6, 1'b0, EV_NONE,      27'd0,          14'd0},
        '{FUNC_KEY,  KEY_HASH,     1'b1, EV_CANCELLED, 27'd7_123_450,  14'd10}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_word   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [HZ_W-1:0]      i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 o_cfg_ready;

    // Model of the entry state and its registers.
    logic              m_entry = 1'b0;
    logic [3:0]        m_digits [DIGITS_MAX] = '{default: 4'd0};
    int                m_count = 0;
    logic [IDLE_W-1:0] m_idle  = '0;
    logic [HZ_W-1:0]   m_freq  = RST_FREQ_HZ;
    logic [1:0]        m_step  = RST_STEP;
    logic [HZ_W-1:0]   if_hz      = RST_IF_HZ;
    logic [IDLE_W-1:0] timeout_ms = RST_TIMEOUT;
    logic [HZ_W-1:0]   min_hz     = RST_MIN_HZ;
    logic [HZ_W-1:0]   max_hz     = RST_MAX_HZ;

    t_out_word status_due [$];
    int err_count       = 0;
    int effective_words = 0;
    int snd_max         = 11;
    int rcv_max         = 11;
    int hold_cycles     = 0;

    keypad_frequency_entry DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Frequency in Hz of the digits typed so far; returns 0 for a bad length.
    function automatic bit entry_to_hz(output int unsigned hz);
        int unsigned d [DIGITS_MAX];
        for (int i = 0; i < DIGITS_MAX; i++) d[i] = m_digits[i];
        hz = (d[0] * 10 + d[1]) * 1_000_000;
        if (m_count == 2) return 1'b1;
        if (m_count < 4) return 1'b0;
        if (m_count == 4) hz += (d[2] * 10 + d[3]) * 10_000;
        else hz += d[2] * 100_000 + d[3] * 10_000 + d[4] * 1_000;
        if (m_count == 6) hz += d[5] * 100;
        else if (m_count == 7) hz += d[5] * 100 + d[6] * 10;
        return 1'b1;
    endfunction

    // Advances the model by one accepted word and returns the status it shows.
    function automatic t_out_word status_after(input t_in_word w);
        t_event      ev;
        logic        is_digit;
        int unsigned hz;
        t_out_word   s;
        ev = EV_NONE;
        is_digit = (w.key >= KEY_0) && (w.key <= KEY_9);
        if (w.func == FUNC_TICK) begin
            if (m_entry) begin
                if (m_idle < IDLE_SAT) m_idle++;
                if (m_idle > timeout_ms) begin
                    m_entry = 1'b0;
                    m_count = 0;
                    ev = EV_TIMED_OUT;
                end
            end
        end else if (m_entry) begin
            if (is_digit) begin
                m_idle = '0;
                if (m_count < DIGITS_MAX) begin
                    m_digits[m_count] = 4'(w.key - KEY_0);
                    m_count++;
                    ev = EV_ADDED;
                end else begin
                    ev = EV_REFUSED;
                end
            end else if (w.key == KEY_A_UPPER || w.key == KEY_A_LOWER) begin
                if (entry_to_hz(hz) && hz >= min_hz && hz <= max_hz) begin
                    m_freq = HZ_W'(hz);
                    ev = EV_ACCEPTED;
                end else begin
                    ev = EV_REJECTED;
                end
                m_entry = 1'b0;
                m_count = 0;
            end else if (w.key == KEY_C_UPPER || w.key == KEY_C_LOWER || w.key == KEY_HASH) begin
                m_entry = 1'b0;
                m_count = 0;
                ev = EV_CANCELLED;
            end
        end else if (w.key == KEY_STAR) begin
            m_step = m_step - 2'd1;
            ev = EV_STEP;
        end else if (w.key == KEY_HASH) begin
            m_step = m_step + 2'd1;
            ev = EV_STEP;
        end else if (is_digit) begin
            m_entry = 1'b1;
            m_digits[0] = 4'(w.key - KEY_0);
            m_count = 1;
            m_idle = '0;
            ev = EV_STARTED;
        end
        s.event_res = ev;
        s.entry_active = m_entry;
        s.digit_count = CNT_W'(m_count);
        s.entered_digits = '0;
        for (int i = 0; i < m_count; i++) s.entered_digits[BCD_W-1-4*i -: 4] = m_digits[i];
        s.tuned_frequency = m_freq;
        s.oscillator_frequency = OSC_W'(m_freq) + OSC_W'(if_hz);
        s.step_hz = STEP_HZ[m_step];
        return s;
    endfunction

    task automatic send_word(input t_in_word w, input logic typed = 1'b0,
                             input t_event ev = EV_NONE,
                             input logic [HZ_W-1:0] hz = '0,
                             input logic [STEP_W-1:0] st = '0);
        int        gap;
        t_out_word s;
        gap = $urandom_range(0, snd_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        s = status_after(w);
        if (typed) begin
            s.event_res = ev;
            s.tuned_frequency = hz;
            s.step_hz = st;
        end
        if (s.event_res != EV_NONE) effective_words++;
        status_due.push_back(s);
    endtask

    task automatic send_key(input logic [7:0] k);
        t_in_word w;
        w.func = FUNC_KEY;
        w.key  = k;
        send_word(w);
    endtask

    task automatic send_tick();
        t_in_word w;
        w.func = FUNC_TICK;
        w.key  = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    // Leaves the input idle until every status word has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (status_due.size() != 0);
    endtask

    task automatic configure(input int unsigned ifh, input int unsigned tmo,
                             input int unsigned lo, input int unsigned hi);
        logic [CFG_IDX_W-1:0] idx  [4];
        logic [HZ_W-1:0]      vals [4];
        idx  = '{CFG_IF_HZ, CFG_TIMEOUT, CFG_MIN_HZ, CFG_MAX_HZ};
        vals = '{HZ_W'(ifh), HZ_W'(tmo), HZ_W'(lo), HZ_W'(hi)};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        end
        i_cfg_valid <= 1'b0;
        if_hz      = HZ_W'(ifh);
        timeout_ms = IDLE_W'(tmo);
        min_hz     = HZ_W'(lo);
        max_hz     = HZ_W'(hi);
    endtask

    // One typed frequency: digits, maybe stray words between them, then an ending or none.
    task automatic type_entry();
        int          n;
        int          r;
        int unsigned v;
        logic [3:0]  dg [DIGITS_MAX];
        logic [7:0]  k;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0:       n = 1;
                1:       n = 3;
                2:       n = 8;
                default: n = 9;
            endcase
        end else begin
            case ($urandom_range(0, 4))
                0:       n = 2;
                1:       n = 4;
                2:       n = 5;
                3:       n = 6;
                default: n = 7;
            endcase
        end
        if ($urandom_range(0, 1) == 1 && min_hz <= max_hz) begin
            // Digits of a frequency inside the limits, so acceptances are common.
            v = $urandom_range(min_hz, max_hz) / 10;
            for (int i = DIGITS_MAX - 1; i >= 0; i--) begin
                dg[i] = 4'(v % 10);
                v = v / 10;
            end
        end else begin
            for (int i = 0; i < DIGITS_MAX; i++) dg[i] = 4'($urandom_range(0, 9));
        end
        for (int i = 0; i < n; i++) begin
            send_key(KEY_0 + 8'(dg[i % DIGITS_MAX]));
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_tick();
                end else begin
                    k = 8'($urandom_range(0, 255));
                    if ((k >= KEY_0 && k <= KEY_9) || k == KEY_A_UPPER || k == KEY_A_LOWER
                        || k == KEY_C_UPPER || k == KEY_C_LOWER || k == KEY_HASH)
                        k = KEY_B_UPPER;
                    send_key(k);
                end
            end
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            send_key($urandom_range(0, 1) ? KEY_A_UPPER : KEY_A_LOWER);
        end else if (r < 80) begin
            case ($urandom_range(0, 2))
                0:       send_key(KEY_C_UPPER);
                1:       send_key(KEY_C_LOWER);
                default: send_key(KEY_HASH);
            endcase
        end else if (r < 90) begin
            repeat ((timeout_ms <= 64) ? timeout_ms + 1 : 3) send_tick();
        end
    endtask

    task automatic run_traffic(input int target);
        int       start;
        int       seqs;
        int       r;
        t_in_word w;
        start = effective_words;
        seqs = 0;
        while (effective_words - start < target) begin
            if (seqs % 12 == 0) begin
                r = $urandom_range(0, 3);
                snd_max = (r == 1 || r == 3) ? 11 : 0;
                rcv_max = (r >= 2) ? 11 : 0;
            end
            seqs++;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                type_entry();
            end else if (r < 70) begin
                repeat ($urandom_range(1, 3))
                    send_key($urandom_range(0, 1) ? KEY_STAR : KEY_HASH);
            end else if (r < 85) begin
                repeat ($urandom_range(1, 5)) send_tick();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    w.func = 1'($urandom_range(0, 1));
                    w.key  = 8'($urandom_range(0, 255));
                    send_word(w);
                end
            end
            if ($urandom_range(0, 49) == 0) drain();
        end
    endtask

    task automatic check_status(input t_out_word want, input t_out_word got);
        if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
            err_count++;
        end
        if (got.entry_active !== want.entry_active) begin
            $error("entry_active: expected %0d, actual %0d",
                   want.entry_active, got.entry_active);
            err_count++;
        end
        if (got.digit_count !== want.digit_count) begin
            $error("digit_count: expected %0d, actual %0d", want.digit_count, got.digit_count);
            err_count++;
        end
        if (got.entered_digits !== want.entered_digits) begin
            $error("entered_digits: expected %h, actual %h",
                   want.entered_digits, got.entered_digits);
            err_count++;
        end
        if (got.tuned_frequency !== want.tuned_frequency) begin
            $error("tuned_frequency: expected %0d, actual %0d",
                   want.tuned_frequency, got.tuned_frequency);
            err_count++;
        end
        if (got.oscillator_frequency !== want.oscillator_frequency) begin
            $error("oscillator_frequency: expected %0d, actual %0d",
                   want.oscillator_frequency, got.oscillator_frequency);
            err_count++;
        end
        if (got.step_hz !== want.step_hz) begin
            $error("step_hz: expected %0d, actual %0d", want.step_hz, got.step_hz);
            err_count++;
        end
    endtask

    // Status receiver: a random hold-off before each word, or a long one on request.
    initial begin
        int k;
        forever begin
            if (hold_cycles > 0) begin
                k = hold_cycles;
                hold_cycles = 0;
            end else begin
                k = $urandom_range(0, rcv_max);
            end
            if (k > 0) begin
                i_out_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (status_due.size() == 0) begin
                $error("status word received with none due");
                err_count++;
            end else begin
                check_status(status_due.pop_front(), o_out_word);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_row        row;
        t_in_word    w;
        int unsigned lo;
        int unsigned hi;
        int unsigned ifh;
        int unsigned tmo;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            row = SCRIPT[i];
            w.func = row.func;
            w.key  = row.key;
            send_word(w, row.typed, row.ev, row.hz, row.step);
        end

        // Widest offset and limits, shortest nonzero timeout.
        drain();
        configure(99_999_999, 1, 0, 99_999_990);
        run_traffic(75);

        // The longest timeout keeps the entry open across idle ticks; then the
        // highest frequency that can be typed is confirmed.
        drain();
        configure(0, 8191, 99_999_990, 99_999_990);
        snd_max = 0;
        rcv_max = 0;
        send_key(KEY_9);
        repeat (20) send_tick();
        repeat (6) send_key(KEY_9);
        send_key(KEY_A_UPPER);
        run_traffic(55);

        // Inverted limits reject everything; a zero timeout ends on one tick.
        drain();
        configure(12_345_678, 0, 50_000_000, 10_000_000);
        run_traffic(75);

        for (int p = 0; p < 6; p++) begin
            drain();
            case ($urandom_range(0, 3))
                0:       ifh = 0;
                1:       ifh = 99_999_999;
                default: ifh = $urandom_range(0, 99_999_999);
            endcase
            tmo = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8191) : $urandom_range(1, 40);
            lo = $urandom_range(0, 20_000_000);
            hi = $urandom_range(lo, 99_999_990);
            if ($urandom_range(0, 5) == 0) configure(ifh, tmo, hi, lo);
            else configure(ifh, tmo, lo, hi);
            // One phase starts with a long output hold so the input backs up.
            if (p == 2) hold_cycles = 400;
            run_traffic(140);
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (err_count == 0 && status_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/kfe_pkg.sv
hdl/kfe_out_buf.sv
hdl/keypad_frequency_entry.sv
hdl/kfe_checker.sv
verif/tb_keypad_frequency_entry.sv
